>>> rtl/core/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// shared types and codes of the countdown timer bank
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int SLOT_W   = 4;
  localparam int DELAY_W  = 64;
  localparam int PAY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int REQ_W    = 2;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam req_t REQ_TICK   = 2'd0;
  localparam req_t REQ_ARM    = 2'd1;
  localparam req_t REQ_DISARM = 2'd2;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_EXPIRED = 3'd1;
  localparam status_t ST_NONE    = 3'd2;
  localparam status_t ST_BUSY    = 3'd3;
  localparam status_t ST_IDLE    = 3'd4;
  localparam status_t ST_ZERO    = 3'd5;

  typedef struct packed {
    logic               armed;
    logic [DELAY_W-1:0] remaining;
    logic [PAY_W-1:0]   payload;
  } cell_t;

endpackage

>>> rtl/core/ctb_cell.sv
// ----------------------------------------------------------------------------
// ctb_cell
// one timer slot of the ring; takes its neighbour's contents on a shift
// ----------------------------------------------------------------------------
module ctb_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  ctb_pkg::cell_t        shift_in,
  input  logic                  wr_en,
  input  logic                  wr_arm,
  input  logic [63:0]           wr_delay,
  input  logic [31:0]           wr_payload,
  output ctb_pkg::cell_t        cell_q
);
  import ctb_pkg::*;

  logic               armed_r;
  logic [DELAY_W-1:0] remaining_r;
  logic [PAY_W-1:0]   payload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
    end else if (shift_en) begin
      armed_r <= shift_in.armed;
    end else if (wr_en) begin
      armed_r <= wr_arm;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (shift_en) begin
      remaining_r <= shift_in.remaining;
      payload_r   <= shift_in.payload;
    end else if (wr_en && wr_arm) begin
      remaining_r <= wr_delay;
      payload_r   <= wr_payload;
    end
  end

  assign cell_q = '{armed: armed_r, remaining: remaining_r, payload: payload_r};

endmodule

>>> rtl/core/countdown_timer_bank.sv
// ----------------------------------------------------------------------------
// countdown_timer_bank
// bank of one-shot countdown timers held in a ring of slot cells
// ----------------------------------------------------------------------------
// Arm and disarm requests each give one result. A tick rotates
// the ring of SLOTS cells once through a single shared decrement and expiry
// check at its head, one slot per cycle except while a held expiry stalls
// on out_ready low, then gives the final result from S_FLUSH. A new request
// is taken only in S_IDLE with the result register free. Expired
// slots come out in ascending slot order, the last flagged by out_last; a
// tick with no expiry gives one "nothing expired" result. Request code 3 is
// taken and gives no result.
module countdown_timer_bank #(
  parameter int SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_req_type,
  input  logic [3:0]            in_slot,
  input  logic [63:0]           in_delay,
  input  logic [31:0]           in_payload,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [3:0]            out_timer_slot,
  output logic [31:0]           out_expired_payload,
  output logic                  out_last
);
  import ctb_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      step_r, step_nxt;
  logic               hold_valid_r, hold_valid_nxt;
  logic [SLOT_W-1:0]  hold_slot_r, hold_slot_nxt;
  logic [PAY_W-1:0]   hold_pay_r, hold_pay_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [PAY_W-1:0]   out_pay_r, out_pay_nxt;
  logic               out_last_r, out_last_nxt;

  cell_t              cell_q [SLOTS];
  cell_t              head_proc;
  logic [SLOTS-1:0]   armed_vec;
  logic               out_free;
  logic               in_acc;
  logic               in_bank;
  logic [6:0]         slot_ext;
  logic               sel_armed;
  logic               arm_ok;
  logic               disarm_ok;
  logic               expire;
  logic               stall;
  logic               shift_en;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;

  assign slot_ext  = {3'b000, in_slot};
  assign in_bank   = 32'(in_slot) < 32'(SLOTS);
  assign sel_armed = armed_vec[slot_ext[IW-1:0]];
  assign arm_ok    = in_acc && (in_req_type == REQ_ARM) && in_bank && !sel_armed
                     && (in_delay != '0);
  assign disarm_ok = in_acc && (in_req_type == REQ_DISARM) && in_bank && sel_armed;

  // shared head: decrement and expiry check
  assign expire   = (state_r == S_SCAN) && cell_q[0].armed
                    && (cell_q[0].remaining == 64'd1);
  assign stall    = expire && hold_valid_r && !out_free;
  assign shift_en = (state_r == S_SCAN) && !stall;

  always_comb begin
    head_proc           = cell_q[0];
    head_proc.armed     = cell_q[0].armed && (cell_q[0].remaining != 64'd1);
    head_proc.remaining = cell_q[0].remaining - {63'd0, cell_q[0].armed};
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic wr_en_c;
    assign wr_en_c      = (arm_ok || disarm_ok) && (slot_ext == 7'(i));
    assign armed_vec[i] = cell_q[i].armed;
    ctb_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (shift_en),
      .shift_in   ((i == SLOTS - 1) ? head_proc : cell_q[(i + 1) % SLOTS]),
      .wr_en      (wr_en_c),
      .wr_arm     (arm_ok),
      .wr_delay   (in_delay),
      .wr_payload (in_payload),
      .cell_q     (cell_q[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    hold_valid_nxt = hold_valid_r;
    hold_slot_nxt  = hold_slot_r;
    hold_pay_nxt   = hold_pay_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_pay_nxt    = out_pay_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            REQ_TICK: begin
              state_nxt      = S_SCAN;
              step_nxt       = '0;
              hold_valid_nxt = 1'b0;
            end
            REQ_ARM: begin
              out_valid_nxt  = 1'b1;
              out_slot_nxt   = in_slot;
              out_pay_nxt    = '0;
              out_last_nxt   = 1'b1;
              if (!in_bank || sel_armed) begin
                out_status_nxt = ST_BUSY;
              end else if (in_delay == '0) begin
                out_status_nxt = ST_ZERO;
              end else begin
                out_status_nxt = ST_OK;
              end
            end
            REQ_DISARM: begin
              out_valid_nxt  = 1'b1;
              out_slot_nxt   = in_slot;
              out_pay_nxt    = '0;
              out_last_nxt   = 1'b1;
              out_status_nxt = disarm_ok ? ST_OK : ST_IDLE;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!stall) begin
          if (expire) begin
            if (hold_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_EXPIRED;
              out_slot_nxt   = hold_slot_r;
              out_pay_nxt    = hold_pay_r;
              out_last_nxt   = 1'b0;
            end
            hold_valid_nxt = 1'b1;
            hold_slot_nxt  = SLOT_W'(step_r);
            hold_pay_nxt   = cell_q[0].payload;
          end
          if (step_r == IW'(SLOTS - 1)) begin
            state_nxt = S_FLUSH;
          end else begin
            step_nxt = step_r + IW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_status_nxt = hold_valid_r ? ST_EXPIRED : ST_NONE;
          out_slot_nxt   = hold_valid_r ? hold_slot_r : '0;
          out_pay_nxt    = hold_valid_r ? hold_pay_r : '0;
          hold_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_slot_r  <= hold_slot_nxt;
    hold_pay_r   <= hold_pay_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_pay_r    <= out_pay_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_timer_slot      = out_slot_r;
  assign out_expired_payload = out_pay_r;
  assign out_last            = out_last_r;

`ifndef ASSERT_OFF
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !in_ready)
    else $error("input taken during scan");

  a_flush_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && out_free) |=> (out_valid_r && out_last_r))
    else $error("flush did not give final result");

  a_hold_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_valid_r)
    else $error("held expiry left in idle");

  a_non_expiry_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_EXPIRED) |-> out_last_r)
    else $error("single result without last");

  a_no_shift_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> (state_r == S_SCAN && $stable(step_r)))
    else $error("scan moved while stalled");
`endif

endmodule
